// File: hw/rtl/lik_pkg.sv
package lik_pkg;

   // Fixed field and datapath widths
   localparam int unsigned NUM_AXES    = 3;
   localparam int unsigned COORD_W     = 16;
   localparam int unsigned LINK_W      = 14;
   localparam int unsigned ANGLE_W     = 15;
   localparam int unsigned ACC_W       = 32;
   localparam int unsigned SQ_IN_W     = 64;
   localparam int unsigned SQ_OUT_W    = 32;
   localparam int unsigned SQ_STEPS    = SQ_IN_W / 2;
   localparam int unsigned MUL_W       = 32;
   localparam int unsigned COR_IN_W    = 34;
   localparam int unsigned COR_W       = 52;
   localparam int unsigned COR_SCALE   = 16;
   localparam int unsigned ATAN_W      = 22;
   localparam int unsigned ATAN_IDX_W  = 5;
   localparam int unsigned NUM_W       = 36;
   localparam int unsigned V_W         = 18;
   localparam int unsigned DIST_W      = 17;
   localparam int unsigned SQR_W       = 28;
   localparam int unsigned D2_W        = 33;
   localparam int unsigned NC_W        = 33;
   localparam int unsigned CSR_ADDR_W  = 4;
   localparam int unsigned CSR_DATA_W  = 32;

   // Angles in 2^-16 degree
   localparam logic signed [ACC_W-1:0] DEG_90     = 32'sd5898240;
   localparam logic signed [ACC_W-1:0] DEG_180    = 32'sd11796480;
   localparam logic signed [ACC_W-1:0] ROUND_HALF = 32'sd512;
   localparam int unsigned             ROUND_SHIFT = 10;
   localparam logic signed [ACC_W-1:0] OUT_MIN    = -32'sd16384;
   localparam logic signed [ACC_W-1:0] OUT_MAX    = 32'sd16383;

   // Link length reset values, 1/16 mm
   localparam logic [LINK_W-1:0] UPPER_RESET = 14'd880;
   localparam logic [LINK_W-1:0] LOWER_RESET = 14'd1240;
   localparam logic [LINK_W-1:0] HIP_RESET   = 14'd440;

   typedef enum logic [1:0] {
      CSR_UPPER_LINK = 2'd0,
      CSR_LOWER_LINK = 2'd1,
      CSR_HIP_OFFSET = 2'd2
   } csr_index_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_STEP,
      ST_MUL_XX,
      ST_MUL_YY,
      ST_SQ_W,
      ST_WAIT_W,
      ST_MUL_VV,
      ST_MUL_ZZ,
      ST_SQ_D,
      ST_WAIT_D,
      ST_COR_ZV,
      ST_WAIT_ZV,
      ST_MUL_AA,
      ST_MUL_BB,
      ST_MUL_AB,
      ST_MUL_AD,
      ST_NUM,
      ST_AC_SETUP,
      ST_AC_MDD,
      ST_AC_MNN,
      ST_AC_SQ,
      ST_AC_WAIT_SQ,
      ST_AC_COR,
      ST_AC_WAIT_COR,
      ST_COR_G,
      ST_WAIT_G,
      ST_OUT
   } state_type;

   // atan(2^-i) in 2^-16 degree
   function automatic logic [ATAN_W-1:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
      logic [ATAN_W-1:0] val;
      unique case (idx)
         5'd0:    val = 22'd2949120;
         5'd1:    val = 22'd1740967;
         5'd2:    val = 22'd919879;
         5'd3:    val = 22'd466945;
         5'd4:    val = 22'd234379;
         5'd5:    val = 22'd117304;
         5'd6:    val = 22'd58665;
         5'd7:    val = 22'd29335;
         5'd8:    val = 22'd14668;
         5'd9:    val = 22'd7334;
         5'd10:   val = 22'd3667;
         5'd11:   val = 22'd1833;
         5'd12:   val = 22'd917;
         5'd13:   val = 22'd458;
         5'd14:   val = 22'd229;
         5'd15:   val = 22'd115;
         5'd16:   val = 22'd57;
         5'd17:   val = 22'd29;
         5'd18:   val = 22'd14;
         5'd19:   val = 22'd7;
         5'd20:   val = 22'd4;
         5'd21:   val = 22'd2;
         5'd22:   val = 22'd1;
         default: val = 22'd0;
      endcase
      return val;
   endfunction

   // Round to 1/64 degree and saturate
   function automatic logic signed [ANGLE_W-1:0] to_servo(input logic signed [ACC_W-1:0] r);
      logic signed [ACC_W-1:0] q;
      q = (r + ROUND_HALF) >>> ROUND_SHIFT;
      if (q < OUT_MIN) begin
         q = OUT_MIN;
      end else if (q > OUT_MAX) begin
         q = OUT_MAX;
      end
      return ANGLE_W'(q);
   endfunction

endpackage

// File: hw/rtl/leg_step_and_inverse_kinematics.sv
// Channel   Direction  Handshake                    Moves
// req_      in         req_valid / req_ready        leg number, target, step per axis
// rsp_      out        rsp_valid / rsp_ready        leg, three servo angles, unreachable
// csr_      in         APB psel/penable, pready=1   link lengths a, b, c
//
// The next item is accepted once the last one has been loaded into the result register
// or dropped; the result is registered and held until taken.
// Most of the work falls to the iterative square-root unit (one bit per cycle), then CORDIC.
// An acos with a zero divisor skips its root and CORDIC run. A leg number not below
// NUM_LEGS is dropped without a result. req_ready is high only while idle.
// Reset is synchronous; it clears the stored foot positions and control and loads the reset link lengths.
// A result waiting on rsp_ready holds the next item in its final state.
module leg_step_and_inverse_kinematics #(
   parameter int NUM_LEGS          = 4,
   parameter int CORDIC_ITERATIONS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_leg_number,
   input  logic signed [lik_pkg::COORD_W-1:0]  req_target_x,
   input  logic signed [lik_pkg::COORD_W-1:0]  req_target_y,
   input  logic signed [lik_pkg::COORD_W-1:0]  req_target_z,
   input  logic signed [lik_pkg::COORD_W-1:0]  req_step_x,
   input  logic signed [lik_pkg::COORD_W-1:0]  req_step_y,
   input  logic signed [lik_pkg::COORD_W-1:0]  req_step_z,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_leg_out,
   output logic signed [lik_pkg::ANGLE_W-1:0]  rsp_servo_hip_angle,
   output logic signed [lik_pkg::ANGLE_W-1:0]  rsp_servo_knee_angle,
   output logic signed [lik_pkg::ANGLE_W-1:0]  rsp_servo_yaw_angle,
   output logic                                rsp_unreachable,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [lik_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [lik_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [lik_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);

   localparam int CW = lik_pkg::COORD_W;
   localparam int AXN = lik_pkg::NUM_AXES;

   lik_pkg::state_type state_ff, state_in;

   // Configuration
   logic [lik_pkg::LINK_W-1:0] upper_ff, lower_ff, hip_ff;
   lik_pkg::csr_index_type     csr_idx;
   logic                       csr_wr;

   // Item and foot state
   logic [1:0]           leg_ff;
   logic signed [CW-1:0] tgt_ff [AXN];
   logic signed [CW-1:0] stp_ff [AXN];
   logic signed [CW-1:0] pos_ff [NUM_LEGS][AXN];
   logic signed [CW-1:0] cur    [AXN];
   logic signed [CW-1:0] nxt    [AXN];
   logic signed [CW:0]   rem_d  [AXN];
   logic signed [CW:0]   sum_d  [AXN];
   logic [CW:0]          arem   [AXN];
   logic [CW:0]          astp   [AXN];
   logic                 leg_ok;

   // Working registers
   logic signed [CW-1:0]                   x_ff, y_ff, z_ff;
   logic [2*lik_pkg::MUL_W-1:0]            prod_ff, t0_ff;
   logic signed [lik_pkg::V_W-1:0]         v_ff, w_s, c_s, v_in;
   logic [lik_pkg::D2_W-1:0]               d2_ff;
   logic [lik_pkg::DIST_W-1:0]             dist_ff;
   logic [lik_pkg::SQR_W-1:0]              aa_ff, bb_ff, ab_ff;
   logic signed [lik_pkg::NUM_W-1:0]       n_al_ff, n_be_ff, n_sel, d_ext;
   logic [lik_pkg::MUL_W-1:0]              d_al_ff, d_be_ff, d_sel, dc_ff;
   logic signed [lik_pkg::NC_W-1:0]        nc_ff;
   logic [lik_pkg::SQ_OUT_W-1:0]           r_ff;
   logic signed [lik_pkg::ACC_W-1:0]       alpha_ff, beta_ff, gamma_ff;
   logic signed [lik_pkg::ACC_W-1:0]       hip_a, knee_a, yaw_a;
   logic                                   sel_ff, flag_ff;

   // Shared units
   logic [lik_pkg::MUL_W-1:0]              mul_a, mul_b;
   logic                                   sq_start, sq_done;
   logic [lik_pkg::SQ_IN_W-1:0]            sq_in;
   logic [lik_pkg::SQ_OUT_W-1:0]           sq_root;
   logic                                   cor_start, cor_done;
   logic signed [lik_pkg::COR_IN_W-1:0]    cor_y, cor_x;
   logic signed [lik_pkg::ACC_W-1:0]       cor_angle;

   // Result register
   logic                                   rsp_valid_ff;
   logic [1:0]                             leg_out_ff;
   logic signed [lik_pkg::ANGLE_W-1:0]     hip_out_ff, knee_out_ff, yaw_out_ff;
   logic                                   unreach_ff;
   logic                                   out_load;

   lik_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (sq_in),
      .done     (sq_done),
      .root     (sq_root)
   );

   lik_cordic #(
      .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
   ) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cor_start),
      .y_in  (cor_y),
      .x_in  (cor_x),
      .done  (cor_done),
      .angle (cor_angle)
   );

   // Configuration port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = lik_pkg::csr_index_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff <= lik_pkg::UPPER_RESET;
         lower_ff <= lik_pkg::LOWER_RESET;
         hip_ff   <= lik_pkg::HIP_RESET;
      end else if (csr_wr) begin
         unique case (csr_idx)
            lik_pkg::CSR_UPPER_LINK: upper_ff <= csr_pwdata[lik_pkg::LINK_W-1:0];
            lik_pkg::CSR_LOWER_LINK: lower_ff <= csr_pwdata[lik_pkg::LINK_W-1:0];
            lik_pkg::CSR_HIP_OFFSET: hip_ff   <= csr_pwdata[lik_pkg::LINK_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         lik_pkg::CSR_UPPER_LINK: csr_prdata = lik_pkg::CSR_DATA_W'(upper_ff);
         lik_pkg::CSR_LOWER_LINK: csr_prdata = lik_pkg::CSR_DATA_W'(lower_ff);
         lik_pkg::CSR_HIP_OFFSET: csr_prdata = lik_pkg::CSR_DATA_W'(hip_ff);
         default:                 csr_prdata = '0;
      endcase
   end

   // Step update: snap to target or add the step with a saturated sum, per axis
   assign leg_ok = int'(leg_ff) < NUM_LEGS;

   always_comb begin
      for (int ax = 0; ax < AXN; ax++) begin
         cur[ax] = '0;
         for (int l = 0; l < NUM_LEGS; l++) begin
            if (leg_ff == 2'(l)) begin
               cur[ax] = pos_ff[l][ax];
            end
         end
         rem_d[ax] = (CW+1)'(tgt_ff[ax]) - (CW+1)'(cur[ax]);
         sum_d[ax] = (CW+1)'(cur[ax]) + (CW+1)'(stp_ff[ax]);
         arem[ax]  = rem_d[ax][CW] ? (CW+1)'(-rem_d[ax]) : (CW+1)'(rem_d[ax]);
         astp[ax]  = stp_ff[ax][CW-1] ? (CW+1)'(-(CW+1)'(stp_ff[ax]))
                                      : (CW+1)'(stp_ff[ax]);
         if (arem[ax] < astp[ax]) begin
            nxt[ax] = tgt_ff[ax];
         end else if (sum_d[ax][CW] != sum_d[ax][CW-1]) begin
            nxt[ax] = sum_d[ax][CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
         end else begin
            nxt[ax] = sum_d[ax][CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int l = 0; l < NUM_LEGS; l++) begin
            for (int ax = 0; ax < AXN; ax++) begin
               pos_ff[l][ax] <= '0;
            end
         end
      end else if (state_ff == lik_pkg::ST_STEP && leg_ok) begin
         for (int l = 0; l < NUM_LEGS; l++) begin
            if (leg_ff == 2'(l)) begin
               for (int ax = 0; ax < AXN; ax++) begin
                  pos_ff[l][ax] <= nxt[ax];
               end
            end
         end
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lik_pkg::ST_IDLE:        if (req_valid) state_in = lik_pkg::ST_STEP;
         lik_pkg::ST_STEP:        state_in = leg_ok ? lik_pkg::ST_MUL_XX : lik_pkg::ST_IDLE;
         lik_pkg::ST_MUL_XX:      state_in = lik_pkg::ST_MUL_YY;
         lik_pkg::ST_MUL_YY:      state_in = lik_pkg::ST_SQ_W;
         lik_pkg::ST_SQ_W:        state_in = lik_pkg::ST_WAIT_W;
         lik_pkg::ST_WAIT_W:      if (sq_done) state_in = lik_pkg::ST_MUL_VV;
         lik_pkg::ST_MUL_VV:      state_in = lik_pkg::ST_MUL_ZZ;
         lik_pkg::ST_MUL_ZZ:      state_in = lik_pkg::ST_SQ_D;
         lik_pkg::ST_SQ_D:        state_in = lik_pkg::ST_WAIT_D;
         lik_pkg::ST_WAIT_D:      if (sq_done) state_in = lik_pkg::ST_COR_ZV;
         lik_pkg::ST_COR_ZV:      state_in = lik_pkg::ST_WAIT_ZV;
         lik_pkg::ST_WAIT_ZV:     if (cor_done) state_in = lik_pkg::ST_MUL_AA;
         lik_pkg::ST_MUL_AA:      state_in = lik_pkg::ST_MUL_BB;
         lik_pkg::ST_MUL_BB:      state_in = lik_pkg::ST_MUL_AB;
         lik_pkg::ST_MUL_AB:      state_in = lik_pkg::ST_MUL_AD;
         lik_pkg::ST_MUL_AD:      state_in = lik_pkg::ST_NUM;
         lik_pkg::ST_NUM:         state_in = lik_pkg::ST_AC_SETUP;
         lik_pkg::ST_AC_SETUP: begin
            if (d_sel != '0) begin
               state_in = lik_pkg::ST_AC_MDD;
            end else if (sel_ff) begin
               state_in = lik_pkg::ST_COR_G;
            end
         end
         lik_pkg::ST_AC_MDD:      state_in = lik_pkg::ST_AC_MNN;
         lik_pkg::ST_AC_MNN:      state_in = lik_pkg::ST_AC_SQ;
         lik_pkg::ST_AC_SQ:       state_in = lik_pkg::ST_AC_WAIT_SQ;
         lik_pkg::ST_AC_WAIT_SQ:  if (sq_done) state_in = lik_pkg::ST_AC_COR;
         lik_pkg::ST_AC_COR:      state_in = lik_pkg::ST_AC_WAIT_COR;
         lik_pkg::ST_AC_WAIT_COR: begin
            if (cor_done) begin
               state_in = sel_ff ? lik_pkg::ST_COR_G : lik_pkg::ST_AC_SETUP;
            end
         end
         lik_pkg::ST_COR_G:       state_in = lik_pkg::ST_WAIT_G;
         lik_pkg::ST_WAIT_G:      if (cor_done) state_in = lik_pkg::ST_OUT;
         lik_pkg::ST_OUT:         if (out_load) state_in = lik_pkg::ST_IDLE;
         default:                 state_in = lik_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lik_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Operand selection for the acos pass in progress
   assign n_sel = sel_ff ? n_be_ff : n_al_ff;
   assign d_sel = sel_ff ? d_be_ff : d_al_ff;
   assign d_ext = lik_pkg::NUM_W'(d_sel);

   // Hip offset subtracted from the signed planar reach
   assign w_s  = lik_pkg::V_W'(sq_root[CW-1:0]);
   assign c_s  = lik_pkg::V_W'(hip_ff);
   assign v_in = (x_ff < 0 ? -w_s : w_s) - c_s;

   // Outputs of the sequencer: unit operands and strobes
   always_comb begin
      req_ready = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      sq_start  = 1'b0;
      sq_in     = t0_ff + prod_ff;
      cor_start = 1'b0;
      cor_y     = '0;
      cor_x     = '0;
      out_load  = 1'b0;
      unique case (state_ff)
         lik_pkg::ST_IDLE: req_ready = 1'b1;
         lik_pkg::ST_MUL_XX: begin
            mul_a = lik_pkg::MUL_W'($unsigned(x_ff[CW-1] ? -x_ff : x_ff));
            mul_b = mul_a;
         end
         lik_pkg::ST_MUL_YY: begin
            mul_a = lik_pkg::MUL_W'($unsigned(y_ff[CW-1] ? -y_ff : y_ff));
            mul_b = mul_a;
         end
         lik_pkg::ST_SQ_W, lik_pkg::ST_SQ_D: sq_start = 1'b1;
         lik_pkg::ST_MUL_VV: begin
            mul_a = lik_pkg::MUL_W'(v_ff[lik_pkg::V_W-1] ? (lik_pkg::V_W-1)'(-v_ff)
                                                        : (lik_pkg::V_W-1)'(v_ff));
            mul_b = mul_a;
         end
         lik_pkg::ST_MUL_ZZ: begin
            mul_a = lik_pkg::MUL_W'($unsigned(z_ff[CW-1] ? -z_ff : z_ff));
            mul_b = mul_a;
         end
         lik_pkg::ST_COR_ZV: begin
            cor_start = 1'b1;
            cor_y     = lik_pkg::COR_IN_W'(z_ff);
            cor_x     = lik_pkg::COR_IN_W'(v_ff);
         end
         lik_pkg::ST_MUL_AA: begin
            mul_a = lik_pkg::MUL_W'(upper_ff);
            mul_b = lik_pkg::MUL_W'(upper_ff);
         end
         lik_pkg::ST_MUL_BB: begin
            mul_a = lik_pkg::MUL_W'(lower_ff);
            mul_b = lik_pkg::MUL_W'(lower_ff);
         end
         lik_pkg::ST_MUL_AB: begin
            mul_a = lik_pkg::MUL_W'(upper_ff);
            mul_b = lik_pkg::MUL_W'(lower_ff);
         end
         lik_pkg::ST_MUL_AD: begin
            mul_a = lik_pkg::MUL_W'(upper_ff);
            mul_b = lik_pkg::MUL_W'(dist_ff);
         end
         lik_pkg::ST_AC_MDD: begin
            mul_a = dc_ff;
            mul_b = dc_ff;
         end
         lik_pkg::ST_AC_MNN: begin
            mul_a = nc_ff[lik_pkg::NC_W-1] ? lik_pkg::MUL_W'(-nc_ff)
                                            : lik_pkg::MUL_W'(nc_ff);
            mul_b = mul_a;
         end
         lik_pkg::ST_AC_SQ: begin
            sq_start = 1'b1;
            sq_in    = t0_ff - prod_ff;
         end
         lik_pkg::ST_AC_COR: begin
            cor_start = 1'b1;
            cor_y     = lik_pkg::COR_IN_W'(r_ff);
            cor_x     = lik_pkg::COR_IN_W'(nc_ff);
         end
         lik_pkg::ST_COR_G: begin
            cor_start = 1'b1;
            if (x_ff < 0) begin
               cor_y = -lik_pkg::COR_IN_W'(y_ff);
               cor_x = -lik_pkg::COR_IN_W'(x_ff);
            end else begin
               cor_y = lik_pkg::COR_IN_W'(y_ff);
               cor_x = lik_pkg::COR_IN_W'(x_ff);
            end
         end
         lik_pkg::ST_OUT: out_load = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      unique case (state_ff)
         lik_pkg::ST_IDLE: begin
            leg_ff    <= req_leg_number;
            tgt_ff[0] <= req_target_x;
            tgt_ff[1] <= req_target_y;
            tgt_ff[2] <= req_target_z;
            stp_ff[0] <= req_step_x;
            stp_ff[1] <= req_step_y;
            stp_ff[2] <= req_step_z;
         end
         lik_pkg::ST_STEP: begin
            x_ff    <= nxt[0];
            y_ff    <= nxt[1];
            z_ff    <= nxt[2];
            flag_ff <= 1'b0;
         end
         lik_pkg::ST_MUL_YY, lik_pkg::ST_MUL_ZZ, lik_pkg::ST_AC_MNN: t0_ff <= prod_ff;
         lik_pkg::ST_WAIT_W: if (sq_done) v_ff <= v_in;
         lik_pkg::ST_SQ_D:   d2_ff <= lik_pkg::D2_W'(t0_ff + prod_ff);
         lik_pkg::ST_WAIT_D: if (sq_done) dist_ff <= lik_pkg::DIST_W'(sq_root);
         lik_pkg::ST_WAIT_ZV: if (cor_done) alpha_ff <= cor_angle;
         lik_pkg::ST_MUL_BB: aa_ff <= lik_pkg::SQR_W'(prod_ff);
         lik_pkg::ST_MUL_AB: bb_ff <= lik_pkg::SQR_W'(prod_ff);
         lik_pkg::ST_MUL_AD: ab_ff <= lik_pkg::SQR_W'(prod_ff);
         lik_pkg::ST_NUM: begin
            n_al_ff <= lik_pkg::NUM_W'(aa_ff) - lik_pkg::NUM_W'(bb_ff)
                       + lik_pkg::NUM_W'(d2_ff);
            n_be_ff <= lik_pkg::NUM_W'(aa_ff) + lik_pkg::NUM_W'(bb_ff)
                       - lik_pkg::NUM_W'(d2_ff);
            d_al_ff <= {prod_ff[lik_pkg::MUL_W-2:0], 1'b0};
            d_be_ff <= {lik_pkg::MUL_W'(ab_ff)} << 1;
            sel_ff  <= 1'b0;
         end
         lik_pkg::ST_AC_SETUP: begin
            dc_ff <= d_sel;
            if (d_sel == '0) begin
               // Zero divisor: acos term is zero
               flag_ff <= 1'b1;
               if (sel_ff) begin
                  beta_ff <= '0;
               end
               sel_ff <= 1'b1;
            end else if (n_sel > d_ext) begin
               nc_ff   <= lik_pkg::NC_W'(d_ext);
               flag_ff <= 1'b1;
            end else if (n_sel < -d_ext) begin
               nc_ff   <= lik_pkg::NC_W'(-d_ext);
               flag_ff <= 1'b1;
            end else begin
               nc_ff <= lik_pkg::NC_W'(n_sel);
            end
         end
         lik_pkg::ST_AC_WAIT_SQ: if (sq_done) r_ff <= sq_root;
         lik_pkg::ST_AC_WAIT_COR: begin
            if (cor_done) begin
               if (sel_ff) begin
                  beta_ff <= cor_angle;
               end else begin
                  alpha_ff <= alpha_ff + cor_angle;
               end
               sel_ff <= 1'b1;
            end
         end
         lik_pkg::ST_WAIT_G: if (cor_done) gamma_ff <= cor_angle;
         default: ;
      endcase
   end

   // Servo mapping: legs 1 and 2 are mirrored
   always_comb begin
      if (leg_ff[0] ^ leg_ff[1]) begin
         hip_a  = alpha_ff + lik_pkg::DEG_90;
         knee_a = lik_pkg::DEG_180 - beta_ff;
         yaw_a  = lik_pkg::DEG_90 - gamma_ff;
      end else begin
         hip_a  = lik_pkg::DEG_90 - alpha_ff;
         knee_a = beta_ff;
         yaw_a  = gamma_ff + lik_pkg::DEG_90;
      end
   end

   // Hold the result until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         leg_out_ff  <= leg_ff;
         hip_out_ff  <= lik_pkg::to_servo(hip_a);
         knee_out_ff <= lik_pkg::to_servo(knee_a);
         yaw_out_ff  <= lik_pkg::to_servo(yaw_a);
         unreach_ff  <= flag_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_leg_out          = leg_out_ff;
   assign rsp_servo_hip_angle  = hip_out_ff;
   assign rsp_servo_knee_angle = knee_out_ff;
   assign rsp_servo_yaw_angle  = yaw_out_ff;
   assign rsp_unreachable      = unreach_ff;

endmodule

// File: hw/rtl/lik_isqrt.sv
module lik_isqrt (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [lik_pkg::SQ_IN_W-1:0]  radicand,
   output logic                         done,
   output logic [lik_pkg::SQ_OUT_W-1:0] root
);

   logic [lik_pkg::SQ_IN_W-1:0] rem_ff, rem_in;
   logic [lik_pkg::SQ_IN_W-1:0] res_ff, res_in;
   logic [lik_pkg::SQ_IN_W-1:0] bit_ff, bit_in;
   logic [$clog2(lik_pkg::SQ_STEPS)-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [lik_pkg::SQ_IN_W:0] trial;

   // One result bit per cycle, restoring method
   always_comb begin
      rem_in  = rem_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {1'b0, res_ff} + {1'b0, bit_ff};
      if (start) begin
         rem_in  = radicand;
         res_in  = '0;
         bit_in  = {2'b01, {(lik_pkg::SQ_IN_W-2){1'b0}}};
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if ({1'b0, rem_ff} >= trial) begin
            rem_in = rem_ff - trial[lik_pkg::SQ_IN_W-1:0];
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == ($clog2(lik_pkg::SQ_STEPS))'(lik_pkg::SQ_STEPS-1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign root = res_ff[lik_pkg::SQ_OUT_W-1:0];

endmodule

// File: hw/rtl/lik_cordic.sv
module lik_cordic #(
   parameter int CORDIC_ITERATIONS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [lik_pkg::COR_IN_W-1:0] y_in,
   input  logic signed [lik_pkg::COR_IN_W-1:0] x_in,
   output logic                               done,
   output logic signed [lik_pkg::ACC_W-1:0]   angle
);

   localparam int CNT_W = $clog2(CORDIC_ITERATIONS);

   logic signed [lik_pkg::COR_W-1:0] x_ff, x_in_nx;
   logic signed [lik_pkg::COR_W-1:0] y_ff, y_in_nx;
   logic signed [lik_pkg::ACC_W-1:0] acc_ff, acc_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic zero_ff, zero_in;
   logic signed [lik_pkg::COR_IN_W-1:0] xs, ys;
   logic signed [lik_pkg::COR_W-1:0] dx, dy;
   logic signed [lik_pkg::ACC_W-1:0] atan_ext;

   assign dx       = x_ff >>> cnt_ff;
   assign dy       = y_ff >>> cnt_ff;
   assign atan_ext = lik_pkg::ACC_W'(lik_pkg::atan_entry(lik_pkg::ATAN_IDX_W'(cnt_ff)));

   // Pre-rotate into the right half plane, then one vectoring step per cycle
   always_comb begin
      x_in_nx = x_ff;
      y_in_nx = y_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      zero_in = zero_ff;
      done_in = 1'b0;
      xs      = x_in;
      ys      = y_in;
      if (start) begin
         zero_in = (x_in == '0) && (y_in == '0);
         acc_in  = '0;
         if (x_in < 0) begin
            acc_in = (y_in >= 0) ? lik_pkg::DEG_180 : -lik_pkg::DEG_180;
            xs     = -x_in;
            ys     = -y_in;
         end
         x_in_nx = lik_pkg::COR_W'(xs) <<< lik_pkg::COR_SCALE;
         y_in_nx = lik_pkg::COR_W'(ys) <<< lik_pkg::COR_SCALE;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (y_ff > 0) begin
            x_in_nx = x_ff + dy;
            y_in_nx = y_ff - dx;
            acc_in  = acc_ff + atan_ext;
         end else begin
            x_in_nx = x_ff - dy;
            y_in_nx = y_ff + dx;
            acc_in  = acc_ff - atan_ext;
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(CORDIC_ITERATIONS-1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in_nx;
      y_ff    <= y_in_nx;
      acc_ff  <= acc_in;
      cnt_ff  <= cnt_in;
      zero_ff <= zero_in;
   end

   assign done  = done_ff;
   assign angle = zero_ff ? '0 : acc_ff;

endmodule

// File: hw/rtl/lik_checker.sv
module lik_protocol_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [1:0]                         rsp_leg_out,
   input logic signed [lik_pkg::ANGLE_W-1:0] rsp_servo_hip_angle,
   input logic signed [lik_pkg::ANGLE_W-1:0] rsp_servo_knee_angle,
   input logic signed [lik_pkg::ANGLE_W-1:0] rsp_servo_yaw_angle,
   input logic                               rsp_unreachable
);

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_leg_out)
         && $stable(rsp_servo_hip_angle) && $stable(rsp_servo_knee_angle)
         && $stable(rsp_servo_yaw_angle) && $stable(rsp_unreachable))
      else $error("result changed while stalled");

   // Busy after taking an item
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready right after accepting an item");

   // A new result appears only at the end of a busy period
   a_rsp_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared while idle");

   // Reset drops any pending result
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind leg_step_and_inverse_kinematics lik_protocol_checker u_lik_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_valid),
   .req_ready            (req_ready),
   .rsp_valid            (rsp_valid),
   .rsp_ready            (rsp_ready),
   .rsp_leg_out          (rsp_leg_out),
   .rsp_servo_hip_angle  (rsp_servo_hip_angle),
   .rsp_servo_knee_angle (rsp_servo_knee_angle),
   .rsp_servo_yaw_angle  (rsp_servo_yaw_angle),
   .rsp_unreachable      (rsp_unreachable)
);

// File: verif/lik_checker.sv
`timescale 1ns / 1ps

module lik_checker #(
   parameter int CORDIC_ITERATIONS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic [1:0]                          req_leg_number,
   input  logic signed [lik_pkg::COORD_W-1:0]  req_target_x,
   input  logic signed [lik_pkg::COORD_W-1:0]  req_target_y,
   input  logic signed [lik_pkg::COORD_W-1:0]  req_target_z,
   input  logic signed [lik_pkg::COORD_W-1:0]  req_step_x,
   input  logic signed [lik_pkg::COORD_W-1:0]  req_step_y,
   input  logic signed [lik_pkg::COORD_W-1:0]  req_step_z,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic [1:0]                          rsp_leg_out,
   input  logic signed [lik_pkg::ANGLE_W-1:0]  rsp_servo_hip_angle,
   input  logic signed [lik_pkg::ANGLE_W-1:0]  rsp_servo_knee_angle,
   input  logic signed [lik_pkg::ANGLE_W-1:0]  rsp_servo_yaw_angle,
   input  logic                                rsp_unreachable,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [lik_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [lik_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   input  logic                                csr_pready,
   output int                                  errors,
   output int                                  pending
);
   import lik_pkg::*;

   localparam longint ONE_DEG = 65536;

   typedef struct packed {
      logic [1:0]                leg;
      logic signed [ANGLE_W-1:0] hip;
      logic signed [ANGLE_W-1:0] knee;
      logic signed [ANGLE_W-1:0] yaw;
      logic                      unreach;
   } servo_set_t;

   servo_set_t servo_queue[$];
   longint     foot[4][3];
   longint     link_a, link_b, link_c;

   const longint atan_steps[24] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58665, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic longint vector_angle(longint y, longint x);
      longint acc, dx, dy;
      acc = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         acc = (y >= 0) ? 180 * ONE_DEG : -180 * ONE_DEG;
         x = -x;
         y = -y;
      end
      x = x * ONE_DEG;
      y = y * ONE_DEG;
      for (int i = 0; i < CORDIC_ITERATIONS && i < 24; i++) begin
         dx = x >>> i;
         dy = y >>> i;
         if (y > 0) begin
            x = x + dy;
            y = y - dx;
            acc = acc + atan_steps[i];
         end else begin
            x = x - dy;
            y = y + dx;
            acc = acc - atan_steps[i];
         end
      end
      return acc;
   endfunction

   function automatic longint arc_cos(longint n, longint d, inout bit flag);
      longint unsigned dd, nn;
      if (d <= 0) begin
         flag = 1'b1;
         return 0;
      end
      if (n > d) begin
         n = d;
         flag = 1'b1;
      end else if (n < -d) begin
         n = -d;
         flag = 1'b1;
      end
      dd = longint'(d) * longint'(d);
      nn = (n < 0) ? -n : n;
      nn = nn * nn;
      return vector_angle(longint'(int_sqrt(dd - nn)), n);
   endfunction

   function automatic logic signed [ANGLE_W-1:0] servo_round(longint r);
      longint q;
      q = (r + 512) >>> 10;
      if (q < -16384) q = -16384;
      if (q > 16383) q = 16383;
      return q[ANGLE_W-1:0];
   endfunction

   // Advance one leg and solve its joint angles
   function automatic servo_set_t solve_leg(logic [1:0] leg, longint tgt[3], longint stp[3]);
      servo_set_t res;
      longint x, y, z, w, v, d2, reach, alpha, beta, gamma, rem, nxt;
      bit flag;
      flag = 1'b0;
      for (int ax = 0; ax < 3; ax++) begin
         rem = tgt[ax] - foot[leg][ax];
         if ((rem < 0 ? -rem : rem) < (stp[ax] < 0 ? -stp[ax] : stp[ax])) begin
            foot[leg][ax] = tgt[ax];
         end else begin
            nxt = foot[leg][ax] + stp[ax];
            foot[leg][ax] = (nxt > 32767) ? 32767 : ((nxt < -32768) ? -32768 : nxt);
         end
      end
      x = foot[leg][0];
      y = foot[leg][1];
      z = foot[leg][2];
      w = longint'(int_sqrt(x * x + y * y));
      if (x < 0) w = -w;
      v = w - link_c;
      d2 = v * v + z * z;
      reach = longint'(int_sqrt(d2));
      alpha = vector_angle(z, v)
            + arc_cos(link_a * link_a - link_b * link_b + d2, 2 * link_a * reach, flag);
      beta = arc_cos(link_a * link_a + link_b * link_b - d2, 2 * link_a * link_b, flag);
      gamma = (x >= 0) ? vector_angle(y, x) : vector_angle(-y, -x);
      res.leg = leg;
      if (leg == 0 || leg == 3) begin
         res.hip = servo_round(90 * ONE_DEG - alpha);
         res.knee = servo_round(beta);
         res.yaw = servo_round(gamma + 90 * ONE_DEG);
      end else begin
         res.hip = servo_round(alpha + 90 * ONE_DEG);
         res.knee = servo_round(180 * ONE_DEG - beta);
         res.yaw = servo_round(90 * ONE_DEG - gamma);
      end
      res.unreach = flag;
      return res;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
      errors++;
   endtask

   assign pending = servo_queue.size();

   initial errors = 0;

   always @(posedge clock) begin
      longint     tgt[3], stp[3];
      servo_set_t want;
      if (reset) begin
         foot = '{default: 0};
         link_a = UPPER_RESET;
         link_b = LOWER_RESET;
         link_c = HIP_RESET;
         servo_queue.delete();
      end else begin
         // Track register writes
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr >> 2)
               CSR_UPPER_LINK: link_a = csr_pwdata[LINK_W-1:0];
               CSR_LOWER_LINK: link_b = csr_pwdata[LINK_W-1:0];
               CSR_HIP_OFFSET: link_c = csr_pwdata[LINK_W-1:0];
               default: ;
            endcase
         end
         // Predict on each accepted item
         if (req_valid && req_ready) begin
            tgt = '{req_target_x, req_target_y, req_target_z};
            stp = '{req_step_x, req_step_y, req_step_z};
            servo_queue.push_back(solve_leg(req_leg_number, tgt, stp));
         end
         // Compare each delivered result with the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (servo_queue.size() == 0) begin
               report_mismatch("results waiting", 1, 0);
            end else begin
               want = servo_queue.pop_front();
               if (rsp_leg_out !== want.leg) report_mismatch("leg", rsp_leg_out, want.leg);
               if (rsp_servo_hip_angle !== want.hip)
                  report_mismatch("hip", rsp_servo_hip_angle, want.hip);
               if (rsp_servo_knee_angle !== want.knee)
                  report_mismatch("knee", rsp_servo_knee_angle, want.knee);
               if (rsp_servo_yaw_angle !== want.yaw)
                  report_mismatch("yaw", rsp_servo_yaw_angle, want.yaw);
               if (rsp_unreachable !== want.unreach)
                  report_mismatch("unreachable", rsp_unreachable, want.unreach);
            end
         end
      end
   end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import lik_pkg::*;

   localparam int IDLE_LIMIT = 6000;
   localparam int SETTLE_CYCLES = 300;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [1:0]                 req_leg_number = '0;
   logic signed [COORD_W-1:0]  req_target_x = '0, req_target_y = '0, req_target_z = '0;
   logic signed [COORD_W-1:0]  req_step_x = '0, req_step_y = '0, req_step_z = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [1:0]                 rsp_leg_out;
   logic signed [ANGLE_W-1:0]  rsp_servo_hip_angle, rsp_servo_knee_angle, rsp_servo_yaw_angle;
   logic                       rsp_unreachable;
   logic                       csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]      csr_paddr = '0;
   logic [CSR_DATA_W-1:0]      csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]      csr_prdata;
   logic                       csr_pready;
   int                         errors, pending;
   bit                         no_gaps = 1'b0;
   int                         idle_cycles = 0;

   always #5 clock = ~clock;

   leg_step_and_inverse_kinematics dut (.*);

   lik_checker u_checker (.*);

   // Stop a hung run
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   function automatic int draw_gap();
      if (no_gaps || $urandom_range(0, 4) == 0) return 0;
      return $urandom_range(0, 17);
   endfunction

   // Receive results with random stalls
   initial begin
      int gap;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = draw_gap();
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         while (!rsp_valid) @(negedge clock);
         @(posedge clock);
         @(negedge clock);
      end
   end

   task automatic send_item(logic [1:0] leg, logic signed [15:0] tx, logic signed [15:0] ty,
                            logic signed [15:0] tz, logic signed [15:0] sx,
                            logic signed [15:0] sy, logic signed [15:0] sz);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_leg_number <= leg;
      req_target_x <= tx;
      req_target_y <= ty;
      req_target_z <= tz;
      req_step_x <= sx;
      req_step_y <= sy;
      req_step_z <= sz;
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(csr_index_type idx, logic [CSR_DATA_W-1:0] val);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'(idx) << 2;
      csr_pwdata <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_links(int a, int b, int c);
      drain();
      csr_write(CSR_UPPER_LINK, a);
      csr_write(CSR_LOWER_LINK, b);
      csr_write(CSR_HIP_OFFSET, c);
   endtask

   function automatic logic signed [15:0] any16();
      return 16'($urandom);
   endfunction

   function automatic logic signed [15:0] near(int span);
      return 16'($urandom_range(0, 2 * span) - span);
   endfunction

   // Mostly reachable walking targets, some full-range noise
   task automatic random_items(int count);
      int kind;
      for (int n = 0; n < count; n++) begin
         kind = $urandom_range(0, 9);
         if (kind < 6) begin
            send_item($urandom_range(0, 3), near(2200), near(2200),
                      16'($urandom_range(0, 3000) - 2600),
                      near(500), near(500), near(500));
         end else if (kind < 8) begin
            send_item($urandom_range(0, 3), any16(), any16(), any16(),
                      any16(), any16(), any16());
         end else if (kind == 8) begin
            send_item($urandom_range(0, 3), any16(), any16(), any16(),
                      16'sh8000, 16'sh7fff, 16'sh8000);
         end else begin
            send_item($urandom_range(0, 3), near(40), near(40), near(40), 0, near(8), 0);
         end
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: origin, snapping, saturation, extremes, every leg
      send_item(0, 0, 0, 0, 0, 0, 0);
      send_item(1, 1500, 300, -1200, 16'sh7fff, 16'sh7fff, 16'sh7fff);
      send_item(2, -1500, -300, -1200, 16'sh8000, 16'sh8000, 16'sh8000);
      send_item(3, 1000, -1000, -800, 100, -100, 50);
      send_item(3, 1000, -1000, -800, 100, -100, 50);
      send_item(0, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
      send_item(0, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
      send_item(0, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
      send_item(1, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000);
      send_item(2, 440, 0, 0, 16'sh7fff, 16'sh7fff, 16'sh7fff);
      send_item(2, -20, 0, 0, 16'sh7fff, 16'sh7fff, 16'sh7fff);
      send_item(1, 0, 0, -2000, 16'sh7fff, 16'sh7fff, 16'sh7fff);
      send_item(3, -1, -1, -1, 1, 1, 1);
      send_item(1, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa);
      send_item(2, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555);

      // Default links, then several settings including the extremes
      random_items(200);
      no_gaps = 1'b1;
      random_items(60);
      no_gaps = 1'b0;

      // Hold off until all results are in
      drain();
      random_items(60);

      set_links(1, 1, 0);
      random_items(150);
      set_links(16383, 16383, 16383);
      random_items(150);
      set_links(0, 1240, 440);
      random_items(60);
      set_links(880, 0, 440);
      random_items(60);
      set_links($urandom, $urandom, $urandom);
      random_items(150);
      drain();
      csr_write(csr_index_type'(2'd3), $urandom);
      set_links(UPPER_RESET, LOWER_RESET, HIP_RESET);
      random_items(260);

      drain();
      if (errors == 0 && pending == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// File: files.f
hw/rtl/lik_pkg.sv
hw/rtl/lik_isqrt.sv
hw/rtl/lik_cordic.sv
hw/rtl/leg_step_and_inverse_kinematics.sv
hw/rtl/lik_checker.sv
verif/lik_checker.sv
verif/tb_top.sv
